[sv/assert_macros.svh]
// Assertion macros shared by the parity constraint checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted.
`define PCC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define PCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PCC_ASSERT(lbl, clk, rst_n, prop, msg)

`define PCC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[sv/pcc_pkg.sv]
// Shared types and constants for the parity constraint checker.
`timescale 1ns / 1ps

package pcc_pkg;

  localparam int FIELD_W = 10;
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Status from the union-find engine to the top level.
  typedef struct packed {
    logic idle;
    logic done;
    logic clash;
  } uf_stat_t;

endpackage

[sv/pcc_if.sv]
// Valid/ready channel interfaces for constraint items and result items.
`timescale 1ns / 1ps

interface pcc_in_if;
  logic                         valid;
  logic                         ready;
  logic [pcc_pkg::FIELD_W-1:0]  first_pos;
  logic [pcc_pkg::FIELD_W-1:0]  last_pos;
  logic                         is_odd;

  modport source (output valid, output first_pos, output last_pos, output is_odd,
                  input ready);
  modport sink (input valid, input first_pos, input last_pos, input is_odd,
                output ready);
endinterface

interface pcc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         contradiction;
  logic [pcc_pkg::COUNT_W-1:0]  consistent_count;

  modport source (output valid, output contradiction, output consistent_count,
                  input ready);
  modport sink (input valid, input contradiction, input consistent_count,
                output ready);
endinterface

[sv/parity_constraint_checker.sv]
// Top level of the parity constraint checker: handshakes, sticky flag and count.
//
//  channel  dir  handshake          payload
//  in_ch    in   valid / ready      first_pos[9:0], last_pos[9:0], is_odd
//  out_ch   out  valid / ready      contradiction, consistent_count[15:0]
//
// An item passes in order through accept, the boundary reduction, engine start,
// four finds, check, two joins, done and result load (a clash skips the joins).
// A find walks to its root and then compresses the path behind it; after a
// contradiction an item skips all memory work. After reset the parent memory is
// swept to identity, all 2*POSITIONS entries, with in_ch.ready low. A waiting
// result holds in the output register while the next item is accepted; a finished
// item stalls only while that register is full and not being taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module parity_constraint_checker #(
  parameter int POSITIONS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  pcc_in_if.sink      in_ch,
  pcc_out_if.source   out_ch
);

  localparam int AW = $clog2(POSITIONS);

  typedef enum logic [1:0] {
    S_IDLE, S_MOD, S_UF, S_RES
  } state_t;

  state_t                      state_r;
  logic                        flag_r;
  logic [pcc_pkg::COUNT_W-1:0] count_r;
  logic                        odd_r;
  logic                        out_valid_r;
  logic                        out_flag_r;
  logic [pcc_pkg::COUNT_W-1:0] out_count_r;

  logic                        in_acc;
  logic                        out_load;
  logic                        mod_start;
  logic                        mod_done;
  logic [AW-1:0]               rem_a, rem_b;
  logic                        uf_start;
  pcc_pkg::uf_stat_t           uf_stat;

  // Accept only when idle and the parent memory sweep has finished.
  assign in_ch.ready = (state_r == S_IDLE) && uf_stat.idle;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Load a finished result once the output register is free or being taken.
  assign out_load = (state_r == S_RES) && (!out_valid_r || out_ch.ready);

  // Skip all memory work once a contradiction has been seen.
  assign mod_start = in_acc && !flag_r;
  assign uf_start  = (state_r == S_MOD) && mod_done;

  pcc_mod #(
    .POSITIONS (POSITIONS)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .first_pos (in_ch.first_pos),
    .last_pos  (in_ch.last_pos),
    .done      (mod_done),
    .rem_a     (rem_a),
    .rem_b     (rem_b)
  );

  pcc_uf #(
    .POSITIONS (POSITIONS)
  ) u_uf (
    .clk   (clk),
    .rst_n (rst_n),
    .start (uf_start),
    .bnd_a (rem_a),
    .bnd_b (rem_b),
    .odd   (odd_r),
    .stat  (uf_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flag_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a new result, or drop the held one once taken.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            odd_r   <= in_ch.is_odd;
            state_r <= flag_r ? S_RES : S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state_r <= S_UF;
          end
        end
        S_UF: begin
          if (uf_stat.done) begin
            if (uf_stat.clash) begin
              flag_r <= 1'b1;
            end else if (count_r != pcc_pkg::COUNT_MAX) begin
              count_r <= count_r + pcc_pkg::COUNT_W'(1);
            end
            state_r <= S_RES;
          end
        end
        S_RES: begin
          // Hold until the output register is free, then load it.
          if (out_load) begin
            out_flag_r  <= flag_r;
            out_count_r <= count_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.contradiction    = out_flag_r;
  assign out_ch.consistent_count = out_count_r;

  `PCC_ASSERT(a_accept_leaves, clk, rst_n, in_acc |=> (state_r != S_IDLE), "accept not taken up")
  `PCC_ASSERT(a_flag_sticky, clk, rst_n, flag_r |=> flag_r, "flag cleared")
  `PCC_ASSERT(a_count_frozen, clk, rst_n, flag_r |=> $stable(count_r), "count moved after flag")

endmodule

[sv/pcc_mod.sv]
// Reduction of both range boundaries modulo the position count by reciprocal multiplication.
`timescale 1ns / 1ps

module pcc_mod #(
  parameter int POSITIONS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pcc_pkg::FIELD_W-1:0]   first_pos,
  input  logic [pcc_pkg::FIELD_W-1:0]   last_pos,
  output logic                          done,
  output logic [$clog2(POSITIONS)-1:0]  rem_a,
  output logic [$clog2(POSITIONS)-1:0]  rem_b
);

  localparam int FW = pcc_pkg::FIELD_W;
  localparam int AW = $clog2(POSITIONS);
  localparam int RW = AW + 1;
  localparam int SH = FW + AW;
  localparam int MW = FW + 2;
  localparam int PW = FW + MW;
  // ceil(2^SH / POSITIONS): (x * RECIP) >> SH is the exact quotient for any FW-bit x.
  localparam logic [MW-1:0] RECIP =
    MW'(((longint'(1) << SH) + longint'(POSITIONS) - longint'(1)) / longint'(POSITIONS));
  localparam logic [RW-1:0] MODULUS = RW'(POSITIONS);

  logic [FW-1:0] xa_r, xb_r;
  logic [FW-1:0] qa_r, qb_r;
  logic [AW-1:0] ra_r, rb_r;
  logic          stage_r;
  logic          done_r;
  logic [FW-1:0] xa_nxt, qa_nxt, qb_nxt;
  logic [FW-1:0] ra_nxt, rb_nxt;
  logic [PW-1:0] prod_a, prod_b;

  // Stage one: quotient from the reciprocal. Stage two: subtract quotient times modulus.
  always_comb begin
    xa_nxt = first_pos - FW'(1);
    prod_a = PW'(xa_nxt) * PW'(RECIP);
    prod_b = PW'(last_pos) * PW'(RECIP);
    qa_nxt = FW'(prod_a >> SH);
    qb_nxt = FW'(prod_b >> SH);
    ra_nxt = xa_r - FW'(qa_r * MODULUS);
    rb_nxt = xb_r - FW'(qb_r * MODULUS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= start;
      done_r  <= stage_r;
    end
    if (start) begin
      xa_r <= xa_nxt;
      xb_r <= last_pos;
      qa_r <= qa_nxt;
      qb_r <= qb_nxt;
    end
    if (stage_r) begin
      ra_r <= AW'(ra_nxt);
      rb_r <= AW'(rb_nxt);
    end
  end

  assign done  = done_r;
  assign rem_a = ra_r;
  assign rem_b = rb_r;

endmodule

[sv/pcc_uf.sv]
// Union-find engine: parent memory, clearing sweep, four finds and two joins.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcc_uf #(
  parameter int POSITIONS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [$clog2(POSITIONS)-1:0]  bnd_a,
  input  logic [$clog2(POSITIONS)-1:0]  bnd_b,
  input  logic                          odd,
  output pcc_pkg::uf_stat_t             stat
);

  localparam int AW    = $clog2(POSITIONS);
  localparam int NODES = 2 * POSITIONS;
  localparam int NW    = $clog2(NODES);
  localparam logic [1:0] SEL_LAST = 2'(3);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_WALK, S_CMP, S_CHECK, S_JOIN0, S_JOIN1, S_DONE
  } state_t;

  state_t          state_r;
  logic [NW-1:0]   clr_r;
  logic [AW-1:0]   a_r, b_r;
  logic            odd_r;
  logic [1:0]      sel_r;
  logic [1:0]      sel_nxt;
  logic [NW-1:0]   node_r, start_r, root_r;
  logic [NW-1:0]   roots_r [4];
  logic            clash_r;
  logic            clash_c;
  logic [NW-1:0]   first_node, next_node;

  logic [NW-1:0]   mem [NODES];
  logic [NW-1:0]   rd_data_r;
  logic            mem_we;
  logic [NW-1:0]   mem_waddr, mem_wdata, mem_raddr;

  // Node k of an item: a, b, a+P, b+P.
  function automatic logic [NW-1:0] node_of(logic [1:0] sel, logic [AW-1:0] a,
                                            logic [AW-1:0] b);
    logic [AW-1:0] bnd;
    bnd = sel[0] ? b : a;
    return NW'(bnd) + (sel[1] ? NW'(POSITIONS) : NW'(0));
  endfunction

  assign sel_nxt    = sel_r + 2'(1);
  assign first_node = NW'(bnd_a);
  assign next_node  = node_of(sel_nxt, a_r, b_r);

  // Odd: a vs b and a+P vs b+P must differ. Even: a vs b+P and a+P vs b.
  always_comb begin
    if (odd_r) begin
      clash_c = (roots_r[0] == roots_r[1]) || (roots_r[2] == roots_r[3]);
    end else begin
      clash_c = (roots_r[0] == roots_r[3]) || (roots_r[2] == roots_r[1]);
    end
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node_r;
    mem_wdata = root_r;
    mem_raddr = node_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = clr_r;
      end
      S_IDLE: begin
        mem_raddr = first_node;
      end
      S_WALK: begin
        mem_raddr = (rd_data_r == node_r) ? start_r : rd_data_r;
      end
      S_CMP: begin
        if (rd_data_r == root_r) begin
          mem_raddr = next_node;
        end else begin
          mem_we    = 1'b1;
          mem_raddr = rd_data_r;
        end
      end
      S_JOIN0: begin
        mem_we    = 1'b1;
        mem_waddr = roots_r[0];
        mem_wdata = odd_r ? roots_r[3] : roots_r[1];
      end
      S_JOIN1: begin
        mem_we    = 1'b1;
        mem_waddr = roots_r[2];
        mem_wdata = odd_r ? roots_r[1] : roots_r[3];
      end
      S_CHECK, S_DONE: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      clash_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + NW'(1);
          if (clr_r == NW'(NODES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            a_r     <= bnd_a;
            b_r     <= bnd_b;
            odd_r   <= odd;
            sel_r   <= '0;
            node_r  <= first_node;
            start_r <= first_node;
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          if (rd_data_r == node_r) begin
            root_r  <= node_r;
            node_r  <= start_r;
            state_r <= S_CMP;
          end else begin
            node_r <= rd_data_r;
          end
        end
        S_CMP: begin
          if (rd_data_r == root_r) begin
            roots_r[sel_r] <= root_r;
            if (sel_r == SEL_LAST) begin
              state_r <= S_CHECK;
            end else begin
              sel_r   <= sel_nxt;
              node_r  <= next_node;
              start_r <= next_node;
              state_r <= S_WALK;
            end
          end else begin
            node_r <= rd_data_r;
          end
        end
        S_CHECK: begin
          clash_r <= clash_c;
          state_r <= clash_c ? S_DONE : S_JOIN0;
        end
        S_JOIN0: begin
          state_r <= S_JOIN1;
        end
        S_JOIN1: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.idle  = (state_r == S_IDLE);
  assign stat.done  = (state_r == S_DONE);
  assign stat.clash = clash_r;

  `PCC_ASSERT(a_start_idle, clk, rst_n, start |-> (state_r == S_IDLE), "start while busy")
  `PCC_ASSERT(a_no_reclear, clk, rst_n, (state_r != S_CLEAR) |=> (state_r != S_CLEAR), "sweep restarted")
  `PCC_ASSERT(a_dual_apart, clk, rst_n, (state_r == S_CHECK) |-> (roots_r[0] != roots_r[2]), "node joined to its dual")
  `PCC_ASSERT(a_cmp_write, clk, rst_n, (mem_we && state_r == S_CMP) |-> (rd_data_r != node_r), "compress wrote a root")

endmodule

[test/parity_verdict_checker.sv]
// Predicts and checks the result items of the parity constraint checker.
`timescale 1ns / 1ps

module parity_verdict_checker #(
  parameter int POSITIONS = 1024
) (
  input  logic clk,
  input  logic rst_n,
  pcc_in_if    in_ch,
  pcc_out_if   out_ch,
  output int   mismatch_count,
  output int   pending_count
);

  localparam int NODE_CNT = 2 * POSITIONS;
  localparam int NODE_W   = $clog2(NODE_CNT);

  typedef struct packed {
    logic                        contradiction;
    logic [pcc_pkg::COUNT_W-1:0] consistent_count;
  } parity_verdict_t;

  // Own copy of the extended-domain union-find and the sticky status.
  logic [NODE_W-1:0]           link_of [0:NODE_CNT-1];
  logic                        chain_broken;
  logic [pcc_pkg::COUNT_W-1:0] agreed_count;
  parity_verdict_t             verdict_q [$];

  function automatic logic [NODE_W-1:0] rep_of(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] head;
    logic [NODE_W-1:0] walk;
    logic [NODE_W-1:0] nxt;
    head = node;
    while (link_of[head] != head) head = link_of[head];
    // Compress the path onto the set representative.
    walk = node;
    while (link_of[walk] != head) begin
      nxt = link_of[walk];
      link_of[walk] = head;
      walk = nxt;
    end
    return head;
  endfunction

  function automatic void merge_sets(input logic [NODE_W-1:0] x,
                                     input logic [NODE_W-1:0] y);
    logic [NODE_W-1:0] rx;
    logic [NODE_W-1:0] ry;
    rx = rep_of(x);
    ry = rep_of(y);
    link_of[rx] = ry;
  endfunction

  function automatic parity_verdict_t apply_constraint(
    input logic [pcc_pkg::FIELD_W-1:0] fp,
    input logic [pcc_pkg::FIELD_W-1:0] lp,
    input logic odd);
    logic [pcc_pkg::FIELD_W-1:0] lo_fld;
    logic [NODE_W-1:0]           lo_same, lo_flip, hi_same, hi_flip;
    logic                        clash;
    parity_verdict_t             v;
    lo_fld  = fp - 1'b1;
    lo_same = NODE_W'(int'(lo_fld) % POSITIONS);
    hi_same = NODE_W'(int'(lp) % POSITIONS);
    lo_flip = NODE_W'(int'(lo_same) + POSITIONS);
    hi_flip = NODE_W'(int'(hi_same) + POSITIONS);
    if (!chain_broken) begin
      if (odd) begin
        clash = (rep_of(lo_same) == rep_of(hi_same)) ||
                (rep_of(lo_flip) == rep_of(hi_flip));
      end else begin
        clash = (rep_of(lo_same) == rep_of(hi_flip)) ||
                (rep_of(lo_flip) == rep_of(hi_same));
      end
      if (clash) begin
        chain_broken = 1'b1;
      end else begin
        if (odd) begin
          merge_sets(lo_same, hi_flip);
          merge_sets(lo_flip, hi_same);
        end else begin
          merge_sets(lo_same, hi_same);
          merge_sets(lo_flip, hi_flip);
        end
        if (agreed_count != pcc_pkg::COUNT_MAX) agreed_count = agreed_count + 1'b1;
      end
    end
    v.contradiction    = chain_broken;
    v.consistent_count = agreed_count;
    return v;
  endfunction

  always @(posedge clk) begin : watch
    parity_verdict_t want;
    if (!rst_n) begin
      for (int i = 0; i < NODE_CNT; i++) link_of[i] = NODE_W'(i);
      chain_broken = 1'b0;
      agreed_count = '0;
      verdict_q.delete();
      mismatch_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        verdict_q.push_back(apply_constraint(in_ch.first_pos, in_ch.last_pos, in_ch.is_odd));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: unexpected result, flag %0b count %0d", $realtime,
                     out_ch.contradiction, out_ch.consistent_count);
          end
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = verdict_q.pop_front();
          if (out_ch.contradiction !== want.contradiction ||
              out_ch.consistent_count !== want.consistent_count) begin
            if (mismatch_count < 10) begin
              $display("%0t: result mismatch, expected flag %0b count %0d, got flag %0b count %0d",
                       $realtime, want.contradiction, want.consistent_count,
                       out_ch.contradiction, out_ch.consistent_count);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
    end
    pending_count <= verdict_q.size();
  end

endmodule

[test/tb_parity_constraint_checker.sv]
// Testbench top: stimulus, flow control and verdict for the parity constraint checker.
`timescale 1ns / 1ps

module tb_parity_constraint_checker;

  localparam int POSITIONS   = 1024;
  localparam int PHASE_ITEMS = 275;
  // Cycles without any handshake before the run is declared hung. Covers the
  // clearing sweep of all 2*POSITIONS nodes after reset and long parent chains
  // under heavy receiver stalls, with a wide margin.
  localparam int HANG_LIMIT  = 100000;
  // Settling time after the last result.
  localparam int TAIL_CYCLES = 64;

  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_SEND_SLOW,
    PACE_RECV_SLOW,
    PACE_BOTH
  } pace_t;

  logic  clk;
  logic  rst_n;
  pace_t pace;
  int    mismatch_count;
  int    pending_count;

  // Hidden prefix parity of each boundary. Constraints built from it always
  // agree with each other, so the sticky flag stays low until the final phase.
  bit    bound_par [0:POSITIONS-1];

  pcc_in_if  in_ch ();
  pcc_out_if out_ch ();

  parity_constraint_checker #(.POSITIONS(POSITIONS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  parity_verdict_checker #(.POSITIONS(POSITIONS)) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Draw one idle cycle for the sender under the current pace.
  function automatic bit sender_idles();
    case (pace)
      PACE_SEND_SLOW: return $urandom_range(0, 99) < 85;
      PACE_BOTH:      return $urandom_range(0, 99) < 12;
      default:        return 1'b0;
    endcase
  endfunction

  // Receiver: decide ready at every falling edge; stall at random by pace.
  always @(negedge clk) begin
    case (pace)
      PACE_RECV_SLOW: out_ch.ready <= $urandom_range(0, 99) >= 85;
      PACE_BOTH:      out_ch.ready <= $urandom_range(0, 99) >= 12;
      default:        out_ch.ready <= 1'b1;
    endcase
  end

  // Send one constraint item. The odd/even claim follows the hidden parity
  // unless lie is set, which flips it into a contradiction. Enter and leave at
  // a falling edge; valid stays high on return so back-to-back items never drop it.
  task automatic push_constraint(input logic [pcc_pkg::FIELD_W-1:0] fp,
                                 input logic [pcc_pkg::FIELD_W-1:0] lp,
                                 input bit lie);
    logic [pcc_pkg::FIELD_W-1:0] lo_b;
    lo_b = fp - 1'b1;
    while (sender_idles()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.first_pos <= fp;
    in_ch.last_pos  <= lp;
    in_ch.is_odd    <= bound_par[lo_b] ^ bound_par[lp] ^ lie;
    // Hold the item until the block takes it.
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid, wait until every expected result has come, then switch pace.
  task automatic settle(input pace_t next_pace);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    pace = next_pace;
    @(negedge clk);
  endtask

  // Random constraint with a shape that exercises the union-find: far pairs
  // merge large sets, near pairs and a small window build and revisit chains,
  // and now and then an empty range.
  task automatic push_random(input int win_base);
    int lo_b;
    int hi_b;
    int shape;
    shape = $urandom_range(0, 9);
    lo_b  = $urandom_range(0, POSITIONS - 1);
    if (shape < 4) begin
      hi_b = $urandom_range(0, POSITIONS - 1);
    end else if (shape < 7) begin
      hi_b = (lo_b + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 8) + POSITIONS) %
             POSITIONS;
    end else if (shape < 9) begin
      lo_b = (win_base + $urandom_range(0, 31)) % POSITIONS;
      hi_b = (win_base + $urandom_range(0, 31)) % POSITIONS;
    end else begin
      hi_b = lo_b;
    end
    push_constraint(pcc_pkg::FIELD_W'(lo_b + 1), pcc_pkg::FIELD_W'(hi_b), 1'b0);
  endtask

  // Directed pairs (first, last): field extremes, a zero first position that
  // wraps to the top boundary, reversed ranges, empty ranges, alternating bits.
  localparam int DIR_N = 18;
  localparam logic [pcc_pkg::FIELD_W-1:0] DIR_FIRST [DIR_N] = '{
    10'd1,   10'd1,   10'd0,   10'd1023, 10'd0,   10'd1023, 10'd512, 10'd1,  10'd700,
    10'd341, 10'd682, 10'd2,   10'd3,    10'd1,   10'd513,  10'd1023, 10'd1, 10'd0
  };
  localparam logic [pcc_pkg::FIELD_W-1:0] DIR_LAST [DIR_N] = '{
    10'd1023, 10'd1,  10'd1023, 10'd1023, 10'd0,  10'd0,   10'd511, 10'd0,  10'd300,
    10'd682,  10'd341, 10'd3,   10'd2,    10'd512, 10'd1023, 10'd1,  10'd1023, 10'd512
  };

  // Watchdog: end the run if no item moves on either channel for too long.
  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_run = 0;
      else idle_run++;
    end
    $display("tb_parity_constraint_checker NOT OK");
    $finish;
  end

  initial begin : stimulus
    int    win_base;
    pace_t plan [4];
    int    lo_b;
    plan = '{PACE_FREE, PACE_SEND_SLOW, PACE_RECV_SLOW, PACE_BOTH};
    pace            = PACE_FREE;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.first_pos = '0;
    in_ch.last_pos  = '0;
    in_ch.is_odd    = 1'b0;
    foreach (bound_par[i]) bound_par[i] = $urandom_range(0, 1);

    // Hold reset, then release it at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items, no idling.
    for (int i = 0; i < DIR_N; i++) push_constraint(DIR_FIRST[i], DIR_LAST[i], 1'b0);

    // Random items in four pacing phases; the sender drains the block fully
    // between phases.
    foreach (plan[p]) begin
      settle(plan[p]);
      win_base = $urandom_range(0, POSITIONS - 1);
      repeat (PHASE_ITEMS) push_random(win_base);
    end

    // Break the chain: either an odd claim on an empty range, or a flipped
    // claim on the full range, whose boundaries are linked since the directed
    // part. Then a few items that the sticky flag must freeze out.
    settle(PACE_BOTH);
    if ($urandom_range(0, 1)) begin
      lo_b = $urandom_range(0, POSITIONS - 1);
      push_constraint(pcc_pkg::FIELD_W'(lo_b + 1), pcc_pkg::FIELD_W'(lo_b), 1'b1);
    end else begin
      push_constraint(10'd1, 10'd1023, 1'b1);
    end
    repeat (6) push_random($urandom_range(0, POSITIONS - 1));

    // Drain, then give any stray result time to show up.
    settle(PACE_BOTH);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_parity_constraint_checker OK");
    end else begin
      $display("tb_parity_constraint_checker NOT OK");
    end
    $finish;
  end

endmodule
